// ===== rtl/qthr_pkg.sv =====
// qthr_pkg: shared constants, types and helper functions for the
// quaternion to heading/roll pipeline. No dependencies.
package qthr_pkg;

    localparam int ZF      = 20;   // fraction bits of the angle accumulator
    localparam int TAB_LEN = 24;   // arctangent table length
    localparam int CW      = 37;   // CORDIC x/y datapath width
    localparam int AW      = 30;   // angle accumulator width
    localparam int PSW     = 30;   // saturated asin argument width
    localparam int SQN     = 29;   // root bits of the square root unit
    localparam int SQW     = 58;   // radicand / remainder width
    localparam int QCW     = 16;   // quaternion component width

    localparam logic [27:0] MILLION = 28'd1000000;

    // atan(2^-i) in degrees, ZF fraction bits
    localparam logic signed [AW-1:0] ATAN_TAB [TAB_LEN] = '{
        30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
        30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
        30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
        30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
        30'sd917,      30'sd458,      30'sd229,      30'sd115,
        30'sd57,       30'sd29,       30'sd14,       30'sd7
    };

    // vector arguments carried through the square root stages
    typedef struct packed {
        logic signed [CW-1:0]  ra;
        logic signed [CW-1:0]  rb;
        logic signed [CW-1:0]  ya;
        logic signed [CW-1:0]  yb;
        logic signed [PSW-1:0] ps;
    } arg_t;

    // one CORDIC lane
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] z;
        logic                 zero;
    } lane_t;

    // two BCD digits of a value below 100: {tens, ones}
    function automatic logic [7:0] dec2(input logic [6:0] v);
        logic [3:0] tens;
        logic [6:0] ones;
        tens = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (v >= 7'(10 * k))
            begin
                tens = 4'(k);
            end
        end
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

endpackage

// ===== rtl/quaternion_to_heading_roll_core.sv =====
// quaternion_to_heading_roll_core: quaternion to roll, pitch, yaw and heading.
// Depends on qthr_pkg.
//
// Usage:
//   s_axis: one word per quaternion, tdata = {quat_z, quat_y, quat_x, quat_w},
//   quat_w in bits 15:0, all signed Q2.14.
//   m_axis: one word per input word, in order, carrying roll_angle,
//   pitch_angle, yaw_magnetic, heading_true (1/2^ANGLE_FRAC_BITS degree),
//   display_value and display_bcd.
//   cfg_wr_en/cfg_wr_data write the declination (signed, same angle units);
//   write it only while no word is in flight.
// Throughput: one word per cycle unless the output stalls. The pipeline has
//   3 product/argument stages, 29 square root stages, one CORDIC setup
//   stage, one stage per CORDIC iteration and 3 finishing stages.
// The whole pipeline advances together; it holds when the output register
//   is full and m_axis_tready is low, and s_axis_tready drops then.
//   Empty pipeline slots are just invalid stages.
// Reset clears all stage valid bits and loads the declination with
//   22.93 degrees. No clearing pass is needed.
module quaternion_to_heading_roll_core
    import qthr_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS   = 7,
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // roll_angle[15:0], pitch_angle[30:16], yaw_magnetic[46:31],
    // heading_true[62:47], display_value[90:63], display_bcd[122:91], zero
    output logic [127:0] m_axis_tdata,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data
);

    localparam int F       = ANGLE_FRAC_BITS;
    localparam int IT      = CORDIC_ITERATIONS;
    localparam int LAT     = 3 + SQN + 1 + IT + 3;
    localparam int RW      = F + 10;          // signed rounded angle
    localparam int MW      = F + 9;           // unsigned angle below 360 deg
    localparam int HW      = F + 18;          // signed heading sum
    localparam int FULL    = 360 << F;
    localparam int QUARTER = 90 << F;
    localparam int HALF_IN = 180 << F;
    localparam int WRAP_N  = 32768 / FULL + 2;
    localparam int DECL_RESET = (2293 * (1 << F) + 50) / 100;
    localparam logic signed [AW-1:0] DEG180 = AW'(180 << ZF);
    localparam logic signed [AW-1:0] DEG360 = AW'(360 << ZF);
    localparam logic signed [AW-1:0] RHALF  = AW'(1 << (ZF - F - 1));

    logic en;
    logic [LAT-1:0] vld_reg;
    logic [15:0] decl_reg;

    assign en            = ~vld_reg[LAT-1] | m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            decl_reg <= 16'(DECL_RESET);
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
            end
            if (cfg_wr_en)
            begin
                decl_reg <= cfg_wr_data;
            end
        end
    end

    // ---------------- stage 1: products
    logic signed [QCW-1:0] qw, qx, qy, qz;
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wy_reg;
    logic signed [31:0] p_zx_reg, p_wz_reg, p_xy_reg, p_zz_reg;

    assign qw = s_axis_tdata[15:0];
    assign qx = s_axis_tdata[31:16];
    assign qy = s_axis_tdata[47:32];
    assign qz = s_axis_tdata[63:48];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_wx_reg <= qw * qx;
            p_yz_reg <= qy * qz;
            p_xx_reg <= qx * qx;
            p_yy_reg <= qy * qy;
            p_wy_reg <= qw * qy;
            p_zx_reg <= qz * qx;
            p_wz_reg <= qw * qz;
            p_xy_reg <= qx * qy;
            p_zz_reg <= qz * qz;
        end
    end

    // ---------------- stage 2: vector arguments, asin argument saturation
    arg_t arg2_next, arg2_reg;
    logic signed [CW-1:0] ps_full;
    localparam logic signed [CW-1:0] Q28 = CW'(1 << 28);

    always_comb
    begin
        arg2_next.ra = (CW'(p_wx_reg) + CW'(p_yz_reg)) <<< 1;
        arg2_next.rb = Q28 - ((CW'(p_xx_reg) + CW'(p_yy_reg)) <<< 1);
        arg2_next.ya = (CW'(p_wz_reg) + CW'(p_xy_reg)) <<< 1;
        arg2_next.yb = Q28 - ((CW'(p_yy_reg) + CW'(p_zz_reg)) <<< 1);
        ps_full      = (CW'(p_wy_reg) - CW'(p_zx_reg)) <<< 1;
        priority if (ps_full > Q28)
        begin
            arg2_next.ps = PSW'(Q28);
        end
        else if (ps_full < -Q28)
        begin
            arg2_next.ps = PSW'(-Q28);
        end
        else
        begin
            arg2_next.ps = PSW'(ps_full);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arg2_reg <= arg2_next;
        end
    end

    // ---------------- stage 3: radicand 1 - s^2 in Q56
    arg_t             sq_arg_reg  [SQN+1];
    logic [SQW-1:0]   sq_rem_reg  [SQN+1];
    logic [SQN-1:0]   sq_root_reg [SQN+1];
    logic signed [59:0] ps_sq;
    localparam logic signed [59:0] ONE56 = 60'sd1 <<< 56;

    assign ps_sq = arg2_reg.ps * arg2_reg.ps;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_arg_reg[0]  <= arg2_reg;
            sq_rem_reg[0]  <= SQW'(ONE56 - ps_sq);
            sq_root_reg[0] <= '0;
        end
    end

    // ---------------- square root: one root bit per stage, MSB first
    for (genvar j = 0; j < SQN; j++)
    begin : g_sqrt
        localparam int K = SQN - 1 - j;
        logic [SQW:0] trial;
        logic         take;

        assign trial = ((SQW+1)'(sq_root_reg[j]) << (K + 1)) + ((SQW+1)'(1) << (2 * K));
        assign take  = {1'b0, sq_rem_reg[j]} >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_arg_reg[j+1]  <= sq_arg_reg[j];
                sq_rem_reg[j+1]  <= take ? SQW'({1'b0, sq_rem_reg[j]} - trial)
                                         : sq_rem_reg[j];
                sq_root_reg[j+1] <= take ? (sq_root_reg[j] | (SQN'(1) << K))
                                         : sq_root_reg[j];
            end
        end
    end

    // ---------------- CORDIC setup: left half plane fold, zero vector flag
    lane_t cr_reg [IT+1][3];
    logic signed [CW-1:0] in_y [3];
    logic signed [CW-1:0] in_x [3];

    assign in_y[0] = sq_arg_reg[SQN].ra;
    assign in_x[0] = sq_arg_reg[SQN].rb;
    assign in_y[1] = CW'(sq_arg_reg[SQN].ps);
    assign in_x[1] = CW'({1'b0, sq_root_reg[SQN]});
    assign in_y[2] = sq_arg_reg[SQN].ya;
    assign in_x[2] = sq_arg_reg[SQN].yb;

    for (genvar l = 0; l < 3; l++)
    begin : g_setup
        lane_t s_next;
        always_comb
        begin
            s_next.zero = (in_x[l] == '0) && (in_y[l] == '0);
            if (in_x[l] < 0)
            begin
                s_next.x = -in_x[l];
                s_next.y = -in_y[l];
                s_next.z = (in_y[l] >= 0) ? DEG180 : -DEG180;
            end
            else
            begin
                s_next.x = in_x[l];
                s_next.y = in_y[l];
                s_next.z = '0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cr_reg[0][l] <= s_next;
            end
        end
    end

    // ---------------- CORDIC iterations, one per stage, three lanes
    for (genvar i = 0; i < IT; i++)
    begin : g_iter
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            lane_t c_in, c_next;
            assign c_in = cr_reg[i][l];
            always_comb
            begin
                c_next.zero = c_in.zero;
                if (c_in.y >= 0)
                begin
                    c_next.x = c_in.x + (c_in.y >>> i);
                    c_next.y = c_in.y - (c_in.x >>> i);
                    c_next.z = c_in.z + ATAN_TAB[i];
                end
                else
                begin
                    c_next.x = c_in.x - (c_in.y >>> i);
                    c_next.y = c_in.y + (c_in.x >>> i);
                    c_next.z = c_in.z - ATAN_TAB[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cr_reg[i+1][l] <= c_next;
                end
            end
        end
    end

    // ---------------- finish 1: wrap to (-180,180], round, per-angle fixups
    function automatic logic signed [RW-1:0] round_angle(input lane_t c);
        logic signed [AW-1:0] a;
        logic signed [AW-1:0] r;
        if (c.zero)
        begin
            a = '0;
        end
        else if (c.z > DEG180)
        begin
            a = c.z - DEG360;
        end
        else if (c.z <= -DEG180)
        begin
            a = c.z + DEG360;
        end
        else
        begin
            a = c.z;
        end
        r = (a + RHALF) >>> (ZF - F);
        return RW'(r);
    endfunction

    logic signed [RW-1:0] ro_f, po_f, yo_f;
    logic signed [RW-1:0] roll1_next, pitch1_next, roll1_reg, pitch1_reg;
    logic signed [RW-1:0] m_s;
    logic [MW-1:0]        yaw1_next, yaw1_reg;

    always_comb
    begin
        ro_f       = round_angle(cr_reg[IT][0]);
        po_f       = round_angle(cr_reg[IT][1]);
        yo_f       = round_angle(cr_reg[IT][2]);
        roll1_next = -ro_f;
        priority if (po_f > RW'(QUARTER))
        begin
            pitch1_next = RW'(QUARTER);
        end
        else if (po_f < -RW'(QUARTER))
        begin
            pitch1_next = -RW'(QUARTER);
        end
        else
        begin
            pitch1_next = po_f;
        end
        m_s = RW'(HALF_IN) - yo_f;
        if (m_s >= RW'(FULL))
        begin
            yaw1_next = MW'(m_s - RW'(FULL));
        end
        else
        begin
            yaw1_next = MW'(m_s);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll1_reg  <= roll1_next;
            pitch1_reg <= pitch1_next;
            yaw1_reg   <= yaw1_next;
        end
    end

    // ---------------- finish 2: heading wrap, absolute roll degrees
    logic signed [HW-1:0] h_acc;
    logic [MW-1:0]        head2_next, head2_reg;
    logic signed [RW-1:0] roll2_reg, pitch2_reg;
    logic [MW-1:0]        yaw2_reg;
    logic [RW-1:0]        roll_abs;
    logic [7:0]           mag2_reg;

    always_comb
    begin
        h_acc = HW'({1'b0, yaw1_reg}) + HW'($signed(decl_reg));
        for (int k = 0; k < WRAP_N; k++)
        begin
            if (h_acc >= HW'(FULL))
            begin
                h_acc = h_acc - HW'(FULL);
            end
            else if (h_acc < 0)
            begin
                h_acc = h_acc + HW'(FULL);
            end
        end
        head2_next = MW'(h_acc);
        roll_abs   = (roll1_reg < 0) ? RW'(-roll1_reg) : RW'(roll1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll2_reg  <= roll1_reg;
            pitch2_reg <= pitch1_reg;
            yaw2_reg   <= yaw1_reg;
            head2_reg  <= head2_next;
            mag2_reg   <= 8'(roll_abs >> F);
        end
    end

    // ---------------- finish 3: display value and BCD, output register
    logic [8:0]  hdeg;
    logic [3:0]  hund;
    logic [6:0]  hrem, mrem;
    logic [27:0] disp;
    logic [31:0] bcd;

    always_comb
    begin
        hdeg = 9'(head2_reg >> F);
        priority if (hdeg >= 9'd300)
        begin
            hund = 4'd3;
        end
        else if (hdeg >= 9'd200)
        begin
            hund = 4'd2;
        end
        else if (hdeg >= 9'd100)
        begin
            hund = 4'd1;
        end
        else
        begin
            hund = 4'd0;
        end
        hrem = 7'(hdeg - 9'(hund) * 9'd100);
        mrem = (mag2_reg >= 8'd100) ? 7'(mag2_reg - 8'd100) : 7'(mag2_reg);
        disp = 28'(mag2_reg) * MILLION + 28'(hdeg);
        bcd  = {dec2(mrem), 12'h000, hund, dec2(hrem)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_axis_tdata <= {5'b0, bcd, disp, 16'(head2_reg), 16'(yaw2_reg),
                             15'(pitch2_reg), 16'(roll2_reg)};
        end
    end

`ifndef SYNTHESIS
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAT-2] |-> (head2_reg < MW'(FULL)))
        else $error("heading not wrapped into one turn");
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAT-3] |-> (yaw1_reg < MW'(FULL)))
        else $error("magnetic yaw not wrapped into one turn");
    a_pitch_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAT-3] |-> (pitch1_reg <= RW'(QUARTER) && pitch1_reg >= -RW'(QUARTER)))
        else $error("pitch beyond ninety degrees");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");
`endif

endmodule
